@@ sv/binary_to_decimal_ascii_core_macros.svh @@
// Assertion macros for the binary-to-decimal ASCII core.
`ifndef BINARY_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define B2DA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define B2DA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/b2da_pkg.sv @@
// Package: types and constants of the binary-to-decimal ASCII core.
package b2da_pkg;

  localparam int DIGIT_DEPTH = 20;
  localparam int DIGIT_W     = 4;
  localparam int IDX_W       = 5;
  localparam int CHAR_W      = 8;
  localparam int VALUE_IN_W  = 64;

  localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;

  // Digit symbol lookup
  localparam logic [15:0][CHAR_W-1:0] SYMBOL_TABLE = {
    8'h46, 8'h45, 8'h44, 8'h43, 8'h42, 8'h41, 8'h39, 8'h38,
    8'h37, 8'h36, 8'h35, 8'h34, 8'h33, 8'h32, 8'h31, 8'h30
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SIGN,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage

@@ sv/binary_to_decimal_ascii_core.sv @@
// Binary-to-decimal ASCII core: shift-and-add-3 conversion, then character output.
// Sequence: shift-and-add-3 conversion, a '-' when the word is negative, a scan from the top
// digit down to the first nonzero one (one digit per cycle), then one character per digit.
// A new word is taken only in idle, after the last character of the previous word has been
// loaded; output stalls hold the sequencer. The scan covers the 20-digit BCD register.
// Reset (rst, synchronous, active high) idles the sequencer and drops out_valid.
`include "binary_to_decimal_ascii_core_macros.svh"

module binary_to_decimal_ascii_core #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [b2da_pkg::VALUE_IN_W-1:0]  value,
  input  logic                             is_signed,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [b2da_pkg::CHAR_W-1:0]      char_code,
  output logic                             last_char
);

  localparam int PAD_W  = ((VALUE_WIDTH + 3) / 4) * 4;
  localparam int ITER   = PAD_W / 4;
  localparam int ITER_W = $clog2(ITER);
  localparam int BCD_W  = b2da_pkg::DIGIT_DEPTH * b2da_pkg::DIGIT_W;
  localparam int WORK_W = BCD_W + PAD_W;

  b2da_pkg::state_t state, state_next;

  logic [b2da_pkg::DIGIT_DEPTH-1:0][b2da_pkg::DIGIT_W-1:0] digits;
  logic [PAD_W-1:0]             mag;
  logic                         neg;
  logic [ITER_W-1:0]            cnt;
  logic [b2da_pkg::IDX_W-1:0]   idx;

  logic                         in_accept;
  logic                         out_free;
  logic [VALUE_WIDTH-1:0]       val_w;
  logic                         neg_in;
  logic [VALUE_WIDTH-1:0]       mag_in;
  logic [WORK_W-1:0]            conv_work;
  logic [b2da_pkg::DIGIT_W-1:0] cur_digit;

  logic                         load_out;
  logic                         idx_dec;
  logic [b2da_pkg::CHAR_W-1:0]  char_next;
  logic                         last_next;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cur_digit = digits[idx];

  // Magnitude of the incoming word, most negative value included
  assign val_w  = value[VALUE_WIDTH-1:0];
  assign neg_in = is_signed && val_w[VALUE_WIDTH-1];
  assign mag_in = neg_in ? (~val_w + VALUE_WIDTH'(1)) : val_w;

  // Conversion step: four shift-and-add-3 passes over BCD digits and magnitude
  always_comb begin
    conv_work = {digits, mag};
    for (int s = 0; s < 4; s++) begin
      for (int d = 0; d < b2da_pkg::DIGIT_DEPTH; d++) begin
        if (conv_work[PAD_W + d*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] > 4'd4) begin
          conv_work[PAD_W + d*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] =
            conv_work[PAD_W + d*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] + 4'd3;
        end
      end
      conv_work = {conv_work[WORK_W-2:0], 1'b0};
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      b2da_pkg::ST_IDLE: begin
        if (in_valid) state_next = b2da_pkg::ST_CONVERT;
      end
      b2da_pkg::ST_CONVERT: begin
        if (cnt == '0) state_next = neg ? b2da_pkg::ST_SIGN : b2da_pkg::ST_SCAN;
      end
      b2da_pkg::ST_SIGN: begin
        if (out_free) state_next = b2da_pkg::ST_SCAN;
      end
      b2da_pkg::ST_SCAN: begin
        if (cur_digit != '0 || idx == '0) state_next = b2da_pkg::ST_EMIT;
      end
      b2da_pkg::ST_EMIT: begin
        if (out_free && idx == '0) state_next = b2da_pkg::ST_IDLE;
      end
      default: state_next = b2da_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall  = 1'b1;
    load_out  = 1'b0;
    idx_dec   = 1'b0;
    char_next = b2da_pkg::SYMBOL_TABLE[cur_digit];
    last_next = 1'b0;
    unique case (state)
      b2da_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      b2da_pkg::ST_CONVERT: begin
      end
      b2da_pkg::ST_SIGN: begin
        load_out  = out_free;
        char_next = b2da_pkg::MINUS_CHAR;
      end
      b2da_pkg::ST_SCAN: begin
        // skip leading zeros, keep the units digit
        idx_dec = (cur_digit == '0) && (idx != '0);
      end
      b2da_pkg::ST_EMIT: begin
        load_out  = out_free;
        last_next = (idx == '0);
        idx_dec   = out_free && (idx != '0);
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= b2da_pkg::ST_IDLE;
      out_valid <= 1'b0;
      neg       <= 1'b0;
      cnt       <= '0;
      idx       <= '0;
    end else begin
      state <= state_next;
      if (in_accept) begin
        neg <= neg_in;
        cnt <= ITER_W'(ITER - 1);
        idx <= b2da_pkg::IDX_W'(b2da_pkg::DIGIT_DEPTH - 1);
      end else begin
        if (state == b2da_pkg::ST_CONVERT) cnt <= cnt - ITER_W'(1);
        if (idx_dec) idx <= idx - b2da_pkg::IDX_W'(1);
      end
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      digits <= '0;
      mag    <= PAD_W'(mag_in);
    end else if (state == b2da_pkg::ST_CONVERT) begin
      {digits, mag} <= conv_work;
    end
    if (load_out) begin
      char_code <= char_next;
      last_char <= last_next;
    end
  end

  // Checks
  `B2DA_ASSERT_NEXT(a_accept_starts, in_accept, state == b2da_pkg::ST_CONVERT,
                    "accepted word did not start conversion")
  `B2DA_ASSERT_NOW(a_char_legal, out_valid,
                   (char_code == b2da_pkg::MINUS_CHAR) ||
                   (char_code >= 8'h30 && char_code <= 8'h39),
                   "output character is neither a digit nor a minus sign")
  `B2DA_ASSERT_NEXT(a_units_last,
                    state == b2da_pkg::ST_EMIT && out_free && idx == '0,
                    state == b2da_pkg::ST_IDLE && out_valid && last_char,
                    "units digit not marked last or sequencer not back to idle")
  `B2DA_ASSERT_NOW(a_minus_not_last, out_valid && char_code == b2da_pkg::MINUS_CHAR,
                   !last_char, "minus sign marked as last character")

endmodule
